### sv/btb_pkg.sv
// shared types and constants for the bone transform blend core
package btb_pkg;

   localparam int CW           = 34;
   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 31;

   localparam logic [16:0] W_ONE   = 17'd65536;
   localparam logic [16:0] LO_PASS = 17'd655;
   localparam logic [16:0] HI_PASS = 17'd64881;
   localparam logic [30:0] ONE30   = 31'h4000_0000;
   // one minus 0.0006 in q30
   localparam logic [30:0] NEAR_C  = 31'd1073097579;
   localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

   localparam logic [30:0] ATAN_TAB [CORDIC_STEPS] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
      31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
      31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
      31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
      31'd127, 31'd63, 31'd31, 31'd15, 31'd7, 31'd3, 31'd1
   };

   typedef logic [1:0] sel_type;
   localparam sel_type SEL_SRC   = 2'd0;
   localparam sel_type SEL_DST   = 2'd1;
   localparam sel_type SEL_LIN   = 2'd2;
   localparam sel_type SEL_SLERP = 2'd3;

   typedef struct packed {
      logic             vec;
      logic             last;
      logic [16:0]      w;
      logic [3:0][31:0] src;
      logic [3:0][31:0] dst;
   } item_type;

   typedef struct packed {
      logic             vec;
      logic             last;
      sel_type          sel;
      logic [16:0]      w;
      logic [3:0][31:0] src;
      logic [3:0][32:0] tgt;
   } meta_type;

endpackage

### sv/btb_req_if.sv
// request channel of the blend core
interface btb_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] src_x;
   logic [31:0] src_y;
   logic [31:0] src_z;
   logic [31:0] src_w;
   logic [31:0] dst_x;
   logic [31:0] dst_y;
   logic [31:0] dst_z;
   logic [31:0] dst_w;
   logic        last_item;

   modport source (output valid, mode, src_x, src_y, src_z, src_w,
                   dst_x, dst_y, dst_z, dst_w, last_item, input ready);
   modport sink (input valid, mode, src_x, src_y, src_z, src_w,
                 dst_x, dst_y, dst_z, dst_w, last_item, output ready);
endinterface

### sv/btb_rsp_if.sv
// response channel of the blend core
interface btb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] res_x;
   logic [31:0] res_y;
   logic [31:0] res_z;
   logic [31:0] res_w;
   logic        res_last;

   modport source (output valid, res_x, res_y, res_z, res_w, res_last, input ready);
   modport sink (input valid, res_x, res_y, res_z, res_w, res_last, output ready);
endinterface

### sv/btb_delay.sv
// enabled shift line that carries side data along the pipeline
module btb_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q = pipe_ff[DEPTH-1];

endmodule

### sv/btb_sqrt.sv
// pipelined integer square root, two radicand bits per stage
module btb_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [60:0] rad,
   output logic [30:0] root
);

   localparam int N  = btb_pkg::SQRT_STEPS;
   localparam int SW = 62;

   logic [SW-1:0] n_ff [N];
   logic [SW-1:0] r_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam logic [SW-1:0] BT = SW'(1) << (2 * (N - 1 - k));
      logic [SW-1:0] ni, ri, tr, no, ro;

      if (k == 0) begin : g_first
         assign ni = {1'b0, rad};
         assign ri = '0;
      end else begin : g_next
         assign ni = n_ff[k-1];
         assign ri = r_ff[k-1];
      end

      always_comb begin
         tr = ri + BT;
         if (ni >= tr) begin
            no = ni - tr;
            ro = (ri >> 1) + BT;
         end else begin
            no = ni;
            ro = ri >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= no;
            r_ff[k] <= ro;
         end
      end
   end

   assign root = r_ff[N-1][30:0];

endmodule

### sv/btb_cordic.sv
// pipelined cordic, vectoring or rotation, one micro-rotation per stage
module btb_cordic #(
   parameter bit ROTATE = 1'b0
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [btb_pkg::CW-1:0]  x_in,
   input  logic signed [btb_pkg::CW-1:0]  y_in,
   input  logic signed [btb_pkg::CW-1:0]  z_in,
   output logic signed [btb_pkg::CW-1:0]  y_out,
   output logic signed [btb_pkg::CW-1:0]  z_out
);

   localparam int N  = btb_pkg::CORDIC_STEPS;
   localparam int CW = btb_pkg::CW;

   logic signed [CW-1:0] x_ff [N];
   logic signed [CW-1:0] y_ff [N];
   logic signed [CW-1:0] z_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic signed [CW-1:0] ANG = CW'(btb_pkg::ATAN_TAB[i]);
      logic signed [CW-1:0] xi, yi, zi, dx, dy, xo, yo, zo;
      logic up;

      if (i == 0) begin : g_first
         assign xi = x_in;
         assign yi = y_in;
         assign zi = z_in;
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
      end

      always_comb begin
         dx = yi >>> i;
         dy = xi >>> i;
         up = ROTATE ? (zi >= 0) : !(yi > 0);
         if (up) begin
            xo = xi - dx;
            yo = yi + dy;
            zo = zi - ANG;
         end else begin
            xo = xi + dx;
            yo = yi - dy;
            zo = zi + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= xo;
            y_ff[i] <= yo;
            z_ff[i] <= zo;
         end
      end
   end

   assign y_out = y_ff[N-1];
   assign z_out = z_ff[N-1];

endmodule

### sv/btb_div.sv
// pipelined restoring divider giving the clamped q30 slerp scale sin / s
module btb_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [btb_pkg::CW-1:0] num,
   input  logic [30:0]                   den,
   output logic [30:0]                   scale
);

   localparam int N = btb_pkg::DIV_STEPS;

   logic [31:0] r_ff   [N];
   logic [30:0] q_ff   [N];
   logic [30:0] d_ff   [N];
   logic        np_ff  [N];
   logic        big_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_step
      logic [31:0] ri, r2, ro;
      logic [30:0] di, qi, qo;
      logic        npi, bigi, bt;

      if (j == 0) begin : g_first
         // integer quotient bit; sin at or above twice s saturates anyway
         always_comb begin
            npi  = num[btb_pkg::CW-1] || (num == '0);
            bigi = num[32:0] >= {1'b0, den, 1'b0};
            di   = den;
            ri   = '0;
            qi   = '0;
            r2   = num[31:0];
         end
      end else begin : g_next
         always_comb begin
            npi  = np_ff[j-1];
            bigi = big_ff[j-1];
            di   = d_ff[j-1];
            ri   = r_ff[j-1];
            qi   = q_ff[j-1];
            r2   = {ri[30:0], 1'b0};
         end
      end

      always_comb begin
         bt = r2 >= {1'b0, di};
         ro = bt ? r2 - {1'b0, di} : r2;
         qo = {qi[29:0], bt};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]   <= ro;
            q_ff[j]   <= qo;
            d_ff[j]   <= di;
            np_ff[j]  <= npi;
            big_ff[j] <= bigi;
         end
      end
   end

   always_comb begin
      if (np_ff[N-1]) begin
         scale = '0;
      end else if (big_ff[N-1] || q_ff[N-1] > btb_pkg::ONE30) begin
         scale = btb_pkg::ONE30;
      end else begin
         scale = q_ff[N-1];
      end
   end

endmodule

### sv/btb_lane.sv
// one component lane: weighted sum, rounding, saturation and pass select
module btb_lane (
   input  logic                 clock,
   input  logic                 en,
   input  btb_pkg::sel_type     sel,
   input  logic signed [31:0]   a,
   input  logic signed [32:0]   b,
   input  logic [30:0]          s0,
   input  logic [30:0]          s1,
   output logic signed [31:0]   res
);

   logic signed [63:0] pa_ff;
   logic signed [64:0] pb_ff;
   btb_pkg::sel_type   sel_ff;
   logic signed [31:0] a_ff;
   logic signed [31:0] b_ff;
   logic signed [31:0] res_ff;
   logic signed [31:0] res_in;
   logic signed [65:0] sum;
   logic signed [35:0] sh;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= $signed({1'b0, s0}) * a;
         pb_ff  <= $signed({1'b0, s1}) * b;
         sel_ff <= sel;
         a_ff   <= a;
         b_ff   <= b[31:0];
      end
   end

   always_comb begin
      sum = pa_ff + pb_ff + 66'sd536870912;
      sh  = 36'(sum >>> 30);
      case (sel_ff)
         btb_pkg::SEL_SRC: res_in = a_ff;
         btb_pkg::SEL_DST: res_in = b_ff;
         default: begin
            if (sh > 36'sd2147483647) begin
               res_in = 32'sh7FFF_FFFF;
            end else if (sh < -36'sd2147483648) begin
               res_in = 32'sh8000_0000;
            end else begin
               res_in = sh[31:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

### sv/bone_transform_blend_core.sv
// bone transform blend core: slerp or linear blend of two operands per item
// accepts one item per cycle while no response is refused
// the depth is set by the square root, two cordic passes and the divider
// the whole pipeline advances together and holds while a response is refused
// synchronous reset clears the valid pipeline and sets the weight register to zero
module bone_transform_blend_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   btb_req_if.sink     req_chan,
   btb_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   localparam int CW       = btb_pkg::CW;
   localparam int PIPE_LEN = 130;
   localparam int UP       = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
   localparam int DN       = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
   localparam logic [63:0] ONE_M = 64'(1) << (2 * FRAC_BITS - 2);
   localparam int MW = $bits(btb_pkg::meta_type);

   logic adv;
   logic vld_ff [PIPE_LEN];
   logic [16:0] weight_ff;
   logic [16:0] w_cur;

   // stage a: capture and dot products
   btb_pkg::item_type  item_in, item_a_ff, item_b_ff;
   logic signed [63:0] prod_a_ff [4];
   logic signed [63:0] dot_b_ff;
   logic signed [65:0] dsum;

   // stage c: cosine and selection
   btb_pkg::meta_type  meta_in, meta_c_ff, meta_s_ff;
   logic               neg;
   logic [63:0]        mag, mc;
   logic [30:0]        c_in, c_c_ff;
   logic [61:0]        csq_d_ff;
   logic [61:0]        rad_full;

   logic [30:0]        s_root, c_v, s_div;
   logic signed [CW-1:0] om, sin0, sin1;
   logic [16:0]        w_ang;
   logic [16:0]        wc0;
   logic signed [51:0] pr0, pr1;
   logic signed [CW-1:0] a0_ff, a1_ff;
   logic [30:0]        sc0, sc1;
   logic               sz;
   logic [MW-1:0]      meta_dly;
   btb_pkg::meta_type  meta_d;
   logic [30:0]        s0_ff, s1_ff, s0_in, s1_in;
   logic [1:0]         tail1_ff, tail2_ff;
   logic signed [31:0] lane_res [4];

   assign adv            = !vld_ff[PIPE_LEN-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else if (csr_we) begin
         weight_ff <= csr_wdata;
      end
   end

   assign w_cur = (weight_ff > btb_pkg::W_ONE) ? btb_pkg::W_ONE : weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LEN; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < PIPE_LEN; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_comb begin
      item_in.vec    = req_chan.mode;
      item_in.last   = req_chan.last_item;
      item_in.w      = w_cur;
      item_in.src[0] = req_chan.src_x;
      item_in.src[1] = req_chan.src_y;
      item_in.src[2] = req_chan.src_z;
      item_in.src[3] = req_chan.src_w;
      item_in.dst[0] = req_chan.dst_x;
      item_in.dst[1] = req_chan.dst_y;
      item_in.dst[2] = req_chan.dst_z;
      item_in.dst[3] = req_chan.dst_w;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_a_ff <= item_in;
         for (int k = 0; k < 4; k++) begin
            prod_a_ff[k] <= $signed(item_in.src[k]) * $signed(item_in.dst[k]);
         end
      end
   end

   // the floored quarter of the full dot sum equals the split-product form
   assign dsum = prod_a_ff[0] + prod_a_ff[1] + prod_a_ff[2] + prod_a_ff[3];

   always_ff @(posedge clock) begin
      if (adv) begin
         item_b_ff <= item_a_ff;
         dot_b_ff  <= 64'(dsum >>> 2);
      end
   end

   always_comb begin
      neg  = dot_b_ff < 0;
      mag  = neg ? 64'(-dot_b_ff) : 64'(dot_b_ff);
      mc   = (mag > ONE_M) ? ONE_M : mag;
      c_in = 31'((mc >> UP) << DN);

      meta_in.vec  = item_b_ff.vec;
      meta_in.last = item_b_ff.last;
      meta_in.w    = item_b_ff.w;
      meta_in.src  = item_b_ff.src;
      if (item_b_ff.w <= btb_pkg::LO_PASS) begin
         meta_in.sel = btb_pkg::SEL_SRC;
      end else if (item_b_ff.w >= btb_pkg::HI_PASS) begin
         meta_in.sel = btb_pkg::SEL_DST;
      end else if (!item_b_ff.vec && c_in < btb_pkg::NEAR_C) begin
         meta_in.sel = btb_pkg::SEL_SLERP;
      end else begin
         meta_in.sel = btb_pkg::SEL_LIN;
      end
      for (int k = 0; k < 4; k++) begin
         // sign flip only on the blending paths of rotation mode
         if (neg && !item_b_ff.vec && (meta_in.sel == btb_pkg::SEL_LIN ||
                                       meta_in.sel == btb_pkg::SEL_SLERP)) begin
            meta_in.tgt[k] = -{item_b_ff.dst[k][31], item_b_ff.dst[k]};
         end else begin
            meta_in.tgt[k] = {item_b_ff.dst[k][31], item_b_ff.dst[k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_c_ff <= meta_in;
         c_c_ff    <= c_in;
         csq_d_ff  <= c_c_ff * c_c_ff;
      end
   end

   assign rad_full = (62'(1) << 60) - csq_d_ff;

   btb_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (rad_full[60:0]),
      .root  (s_root)
   );

   btb_delay #(.WIDTH(31), .DEPTH(32)) u_dly_c (
      .clock (clock), .en (adv), .d (c_c_ff), .q (c_v)
   );

   btb_cordic #(.ROTATE(1'b0)) u_angle (
      .clock (clock),
      .en    (adv),
      .x_in  ({3'b000, c_v}),
      .y_in  ({3'b000, s_root}),
      .z_in  ('0),
      .y_out (),
      .z_out (om)
   );

   btb_delay #(.WIDTH(17), .DEPTH(62)) u_dly_w (
      .clock (clock), .en (adv), .d (meta_c_ff.w), .q (w_ang)
   );

   always_comb begin
      wc0 = btb_pkg::W_ONE - w_ang;
      pr0 = om * $signed({1'b0, wc0});
      pr1 = om * $signed({1'b0, w_ang});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff <= CW'(pr0 >>> 16);
         a1_ff <= CW'(pr1 >>> 16);
      end
   end

   btb_cordic #(.ROTATE(1'b1)) u_sin0 (
      .clock (clock), .en (adv),
      .x_in  (btb_pkg::CORDIC_K), .y_in ('0), .z_in (a0_ff),
      .y_out (sin0), .z_out ()
   );

   btb_cordic #(.ROTATE(1'b1)) u_sin1 (
      .clock (clock), .en (adv),
      .x_in  (btb_pkg::CORDIC_K), .y_in ('0), .z_in (a1_ff),
      .y_out (sin1), .z_out ()
   );

   btb_delay #(.WIDTH(31), .DEPTH(61)) u_dly_s (
      .clock (clock), .en (adv), .d (s_root), .q (s_div)
   );

   btb_div u_div0 (
      .clock (clock), .en (adv), .num (sin0), .den (s_div), .scale (sc0)
   );

   btb_div u_div1 (
      .clock (clock), .en (adv), .num (sin1), .den (s_div), .scale (sc1)
   );

   btb_delay #(.WIDTH(1), .DEPTH(92)) u_dly_sz (
      .clock (clock), .en (adv), .d (s_root == '0), .q (sz)
   );

   btb_delay #(.WIDTH(MW), .DEPTH(124)) u_dly_meta (
      .clock (clock), .en (adv), .d (meta_c_ff), .q (meta_dly)
   );

   assign meta_d = btb_pkg::meta_type'(meta_dly);

   always_comb begin
      if (meta_d.sel == btb_pkg::SEL_SLERP && !sz) begin
         s0_in = sc0;
         s1_in = sc1;
      end else begin
         s0_in = 31'(btb_pkg::W_ONE - meta_d.w) << 14;
         s1_in = 31'(meta_d.w) << 14;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_s_ff <= meta_d;
         s0_ff     <= s0_in;
         s1_ff     <= s1_in;
         tail1_ff  <= {meta_s_ff.vec, meta_s_ff.last};
         tail2_ff  <= tail1_ff;
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      btb_lane u_lane (
         .clock (clock),
         .en    (adv),
         .sel   (meta_s_ff.sel),
         .a     ($signed(meta_s_ff.src[k])),
         .b     ($signed(meta_s_ff.tgt[k])),
         .s0    (s0_ff),
         .s1    (s1_ff),
         .res   (lane_res[k])
      );
   end

   assign rsp_chan.valid    = vld_ff[PIPE_LEN-1];
   assign rsp_chan.res_x    = lane_res[0];
   assign rsp_chan.res_y    = lane_res[1];
   assign rsp_chan.res_z    = lane_res[2];
   // vector items always report w as zero
   assign rsp_chan.res_w    = tail2_ff[1] ? '0 : lane_res[3];
   assign rsp_chan.res_last = tail2_ff[0];

endmodule

### tb/sv/btb_blend_checker.sv
// checker for the blend core: watches both channels, predicts each result and compares
`timescale 1ns / 100ps

module btb_blend_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   btb_req_if          req_mon,
   btb_rsp_if          rsp_mon,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata,
   output int          errors,
   output int          pending,
   output int          checked
);

   localparam int UP = (FRAC_BITS * 2 >= 32) ? FRAC_BITS * 2 - 32 : 0;
   localparam int DN = (FRAC_BITS * 2 < 32) ? 32 - FRAC_BITS * 2 : 0;
   localparam longint Q30 = 64'sd1 << 30;
   localparam longint NEAR_LIM = 64'sd644245;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      logic        last;
   } blend_res_type;

   blend_res_type blend_queue[$];
   logic [16:0]   weight_reg;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // vectoring pass: angle of (x, y) in q30 radians
   function automatic longint vec_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < btb_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + longint'(btb_pkg::ATAN_TAB[i]);
         end else begin
            x = x - dx; y = y + dy; z = z - longint'(btb_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint rot_sine(longint z);
      longint x, y, dx, dy;
      x = longint'(btb_pkg::CORDIC_K);
      y = 0;
      for (int i = 0; i < btb_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(btb_pkg::ATAN_TAB[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(btb_pkg::ATAN_TAB[i]);
         end
      end
      return y;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v < 0) return 0;
      return (v > Q30) ? Q30 : v;
   endfunction

   function automatic logic [31:0] weigh(longint a, longint b, longint s0, longint s1);
      longint r;
      r = (s0 * a + s1 * b + (64'sd1 << 29)) >>> 30;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic blend_res_type blend_predict(logic vec, logic [3:0][31:0] sv,
                                                   logic [3:0][31:0] dv, logic last,
                                                   logic [16:0] wreg);
      longint          src[4], dst[4], tgt[4], res[4];
      longint          s0, s1, hi, p, c, s, om, a0, a1;
      longint unsigned lo, m;
      longint          w;
      logic            neg;
      blend_res_type   r;
      w = (wreg > btb_pkg::W_ONE) ? 64'sd65536 : longint'(wreg);
      for (int k = 0; k < 4; k++) begin
         src[k] = longint'($signed(sv[k]));
         dst[k] = longint'($signed(dv[k]));
         tgt[k] = dst[k];
      end
      if (w <= longint'(btb_pkg::LO_PASS)) begin
         res = src;
      end else if (w >= longint'(btb_pkg::HI_PASS)) begin
         res = dst;
      end else begin
         s0 = (65536 - w) <<< 14;
         s1 = w <<< 14;
         if (!vec) begin
            hi = 0;
            lo = 0;
            for (int k = 0; k < 4; k++) begin
               p  = src[k] * dst[k];
               hi = hi + (p >>> 2);
               lo = lo + longint'(p & 64'sd3);
            end
            hi  = hi + longint'(lo >> 2);
            neg = hi < 0;
            m   = neg ? longint'(-hi) : hi;
            if (m > (64'd1 << (FRAC_BITS * 2 - 2))) m = 64'd1 << (FRAC_BITS * 2 - 2);
            c = longint'((m >> UP) << DN);
            if (neg) for (int k = 0; k < 4; k++) tgt[k] = -dst[k];
            if (Q30 - c > NEAR_LIM) begin
               s = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
               // a zero sine keeps the linear scales
               if (s != 0) begin
                  om = vec_angle(c, s);
                  a0 = (om * (65536 - w)) >>> 16;
                  a1 = (om * w) >>> 16;
                  s0 = clamp_unit(rot_sine(a0) * Q30 / s);
                  s1 = clamp_unit(rot_sine(a1) * Q30 / s);
               end
            end
         end
         for (int k = 0; k < 4; k++) res[k] = longint'($signed(weigh(src[k], tgt[k], s0, s1)));
      end
      r.x    = res[0][31:0];
      r.y    = res[1][31:0];
      r.z    = res[2][31:0];
      r.w    = vec ? 32'd0 : res[3][31:0];
      r.last = last;
      return r;
   endfunction

   always @(posedge clock) begin
      blend_res_type exp_res, got;
      if (reset) begin
         weight_reg = '0;
         blend_queue.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (csr_we) weight_reg = csr_wdata;
         if (req_mon.valid && req_mon.ready)
            blend_queue.push_back(blend_predict(req_mon.mode,
               {req_mon.src_w, req_mon.src_z, req_mon.src_y, req_mon.src_x},
               {req_mon.dst_w, req_mon.dst_z, req_mon.dst_y, req_mon.dst_x},
               req_mon.last_item, weight_reg));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.x    = rsp_mon.res_x;
            got.y    = rsp_mon.res_y;
            got.z    = rsp_mon.res_z;
            got.w    = rsp_mon.res_w;
            got.last = rsp_mon.res_last;
            if (blend_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result item with nothing expected: %h %h %h %h last %b",
                           $realtime, got.x, got.y, got.z, got.w, got.last);
            end else begin
               exp_res = blend_queue.pop_front();
               checked++;
               if (got.x !== exp_res.x || got.y !== exp_res.y || got.z !== exp_res.z ||
                   got.w !== exp_res.w || got.last !== exp_res.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: expected %h %h %h %h last %b, got %h %h %h %h last %b",
                              $realtime, exp_res.x, exp_res.y, exp_res.z, exp_res.w,
                              exp_res.last, got.x, got.y, got.z, got.w, got.last);
               end
            end
         end
      end
      pending = blend_queue.size();
   end
endmodule

### tb/sv/tb_bone_transform_blend_core.sv
// testbench top for the bone transform blend core: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_bone_transform_blend_core;

   localparam int FRAC_BITS = 16;
   localparam int LATENCY = 130;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [16:0] csr_wdata = '0;
   int          errors, pending, checked;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          sent = 0;
   int          settings_done = 0;

   btb_req_if req_bus();
   btb_rsp_if rsp_bus();

   bone_transform_blend_core #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock(clock), .reset(reset), .req_chan(req_bus), .rsp_chan(rsp_bus),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   btb_blend_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending), .checked(checked)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = 1'b0;
      req_bus.src_x = '0; req_bus.src_y = '0; req_bus.src_z = '0; req_bus.src_w = '0;
      req_bus.dst_x = '0; req_bus.dst_y = '0; req_bus.dst_z = '0; req_bus.dst_w = '0;
      req_bus.last_item = 1'b0;
      rsp_bus.ready = 1'b1;
   end

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;

   task automatic send_item(logic mode, logic [3:0][31:0] s, logic [3:0][31:0] d, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.mode = mode;
      {req_bus.src_w, req_bus.src_z, req_bus.src_y, req_bus.src_x} = s;
      {req_bus.dst_w, req_bus.dst_z, req_bus.dst_y, req_bus.dst_x} = d;
      req_bus.last_item = last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic set_weight(logic [16:0] wv);
      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = wv;
      @(negedge clock);
      csr_we = 1'b0;
      settings_done++;
   endtask

   function automatic logic [31:0] rand_comp(int kind);
      case (kind)
         0: return $urandom();
         1: return 32'($signed($urandom_range(131072)) - 65536);
         default: return 32'($signed($urandom_range(2048)) - 1024);
      endcase
   endfunction

   task automatic send_random();
      logic [3:0][31:0] s, d;
      int kind, pick;
      pick = $urandom_range(99);
      kind = (pick < 30) ? 0 : 1;
      for (int k = 0; k < 4; k++) begin
         s[k] = rand_comp(kind);
         d[k] = rand_comp(kind);
      end
      // near-parallel or near-opposite pairs reach the linear fallback
      if (pick >= 75) begin
         for (int k = 0; k < 4; k++) d[k] = s[k] + rand_comp(2);
         if (pick >= 88) for (int k = 0; k < 4; k++) d[k] = -d[k];
      end
      send_item($urandom_range(3) == 0, s, d, 1'($urandom_range(1)));
   endtask

   logic [16:0] weights[] = '{17'd0, 17'd655, 17'd656, 17'd16384, 17'd64880, 17'd64881,
                              17'd65536, 17'd65537, 17'd131071, 17'd40000, 17'd1000};

   initial begin
      logic [3:0][31:0] q1, q2;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      set_weight(17'd32768);
      q1 = {32'h0001_0000, 32'h0, 32'h0, 32'h0};
      q2 = {32'h0000_B505, 32'h0, 32'h0, 32'h0000_B505};
      send_item(1'b0, q1, q1, 1'b0);                          // identical
      send_item(1'b0, q1, -q1, 1'b1);                         // opposite, negative dot
      send_item(1'b0, q1, q2, 1'b0);                          // 45 degrees apart
      send_item(1'b0, q2, {-q1[3], q1[2], q1[1], q1[0]}, 1'b0);
      send_item(1'b0, q1, {32'h0, 32'h0, 32'h0001_0000, 32'h0}, 1'b0); // orthogonal
      send_item(1'b0, q1, {32'h0000_FFFF, 32'h0, 32'h0, 32'h0000_0100}, 1'b1); // near
      send_item(1'b0, {4{32'h7FFF_FFFF}}, {4{32'h7FFF_FFFF}}, 1'b0);
      send_item(1'b0, {4{32'h8000_0000}}, {4{32'h7FFF_FFFF}}, 1'b1);
      send_item(1'b0, {4{32'h8000_0000}}, {4{32'h8000_0000}}, 1'b0);
      send_item(1'b0, '0, '0, 1'b0);
      send_item(1'b0, '0, q1, 1'b1);
      send_item(1'b1, {32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
                {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000}, 1'b1);
      send_item(1'b1, {4{32'h7FFF_FFFF}}, {4{32'h7FFF_FFFF}}, 1'b0);
      send_item(1'b1, {4{32'h8000_0000}}, {4{32'h8000_0000}}, 1'b0);
      send_item(1'b1, {4{32'hFFFF_FFFF}}, '0, 1'b1);
      send_item(1'b0, {4{32'hFFFF_FFFF}}, {4{32'h0000_0001}}, 1'b0);

      for (int ph = 0; ph < weights.size(); ph++) begin
         set_weight(weights[ph]);
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 36 : 58) : 0;
         stall_pct     = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 36 : 58) : 0;
         repeat (60) send_random();
         for (int k = 0; k < 4; k++) q1[k] = rand_comp(1);
         send_item(1'b0, q1, q1, 1'b0);
         send_item(1'b1, q1, -q1, 1'b1);
         repeat (45) send_random();
      end
      // last stretch with random weights
      for (int ph = 0; ph < 4; ph++) begin
         set_weight(17'($urandom_range(65536)));
         send_idle_pct = ph * 19;
         stall_pct = 58 - ph * 19;
         repeat (40) send_random();
      end

      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      stall_pct = 0;
      $display("%0d items sent over %0d weight settings, %0d results checked",
               sent, settings_done, checked);
      $display("covered rotation and vector modes, pass-through and slerp ranges");
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #3ms;
      $display("timeout after %0d items, %0d results still expected", sent, pending);
      $display("Mismatches found");
      $finish;
   end
endmodule

### filelist.f
sv/btb_pkg.sv
sv/btb_req_if.sv
sv/btb_rsp_if.sv
sv/btb_delay.sv
sv/btb_sqrt.sv
sv/btb_cordic.sv
sv/btb_div.sv
sv/btb_lane.sv
sv/bone_transform_blend_core.sv
tb/sv/btb_blend_checker.sv
tb/sv/tb_bone_transform_blend_core.sv
